// ===== design/ovpc_pkg.sv =====
// ============================================================================
// ovpc_pkg
// Shared types and constants of the occlusion vote patch cost block.
// ============================================================================
package ovpc_pkg;

  // error sum register and its saturation point
  localparam int unsigned ESUM_W = 20;
  localparam logic [ESUM_W-1:0] ESUM_MAX = '1;

  // quotient bits produced by the divider; draw cost saturates at 2.0 in Q2.16
  localparam int unsigned QUO_W = 18;
  localparam logic [QUO_W-1:0] DRAW_MAX = 18'd131072;

  // three channels times full color scale
  localparam int unsigned CHAN_SCALE = 765;

  localparam int unsigned SAMPLE_W  = 12;
  localparam int unsigned CENTRAL_W = 8;
  localparam int unsigned THSUM_W   = 14;
  localparam int unsigned VOTE_W    = 7;
  localparam int unsigned DRAW_W    = 18;
  localparam int unsigned TOTAL_W   = 23;
  localparam int unsigned STEP_W    = $clog2(QUO_W);

  typedef enum logic [2:0] {
    ST_ACCUM,
    ST_SETUP,
    ST_CHECK,
    ST_DIV,
    ST_FINISH
  } ctrl_state_t;

  // controller -> datapath
  typedef struct packed {
    logic acc;     // accept a view sample
    logic setup;   // form the divisor, capture few-views flag
    logic check;   // overflow test, preload remainder
    logic step;    // one restoring-division step
    logic load;    // write result registers, clear the patch
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic few;     // in-view count at most one
    logic sat;     // quotient would overflow
  } dp_stat_t;

endpackage

// ===== design/ovpc_ctrl.sv =====
// ============================================================================
// ovpc_ctrl
// Sequencer: accumulate samples, then set up and run the end-of-patch divide.
// ============================================================================
module ovpc_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_last_view,
  input  logic                 out_stall,
  input  ovpc_pkg::dp_stat_t   stat,
  output ovpc_pkg::ctrl_cmd_t  cmd,
  output logic                 in_stall,
  output logic                 out_valid
);

  ovpc_pkg::ctrl_state_t state_r, state_nxt;
  logic [ovpc_pkg::STEP_W-1:0] cnt_r, cnt_nxt;
  logic out_valid_r, out_valid_nxt;
  logic slot_free;

  assign slot_free = !out_valid_r || !out_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ovpc_pkg::ST_ACCUM: begin
        if (in_valid && in_last_view) state_nxt = ovpc_pkg::ST_SETUP;
      end
      ovpc_pkg::ST_SETUP: begin
        state_nxt = stat.few ? ovpc_pkg::ST_FINISH : ovpc_pkg::ST_CHECK;
      end
      ovpc_pkg::ST_CHECK: begin
        state_nxt = stat.sat ? ovpc_pkg::ST_FINISH : ovpc_pkg::ST_DIV;
      end
      ovpc_pkg::ST_DIV: begin
        if (cnt_r == '0) state_nxt = ovpc_pkg::ST_FINISH;
      end
      ovpc_pkg::ST_FINISH: begin
        if (slot_free) state_nxt = ovpc_pkg::ST_ACCUM;
      end
      default: state_nxt = ovpc_pkg::ST_ACCUM;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    cnt_nxt  = cnt_r;
    unique case (state_r)
      ovpc_pkg::ST_ACCUM: begin
        in_stall = 1'b0;
        cmd.acc  = in_valid;
      end
      ovpc_pkg::ST_SETUP: begin
        cmd.setup = 1'b1;
      end
      ovpc_pkg::ST_CHECK: begin
        cmd.check = 1'b1;
        cnt_nxt   = ovpc_pkg::STEP_W'(ovpc_pkg::QUO_W - 1);
      end
      ovpc_pkg::ST_DIV: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r - 1'b1;
      end
      ovpc_pkg::ST_FINISH: begin
        cmd.load = slot_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load)           out_valid_nxt = 1'b1;
    else if (!out_stall)    out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ovpc_pkg::ST_ACCUM;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== design/ovpc_dpath.sv =====
// ============================================================================
// ovpc_dpath
// Sample scoring, patch accumulators, serial divider and result registers.
// ============================================================================
module ovpc_dpath #(
  parameter int unsigned VIEWS     = 81,
  parameter int unsigned FRAC_BITS = 4
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  ovpc_pkg::ctrl_cmd_t                  cmd,
  output ovpc_pkg::dp_stat_t                   stat,
  input  logic [ovpc_pkg::SAMPLE_W-1:0]        sample_red,
  input  logic [ovpc_pkg::SAMPLE_W-1:0]        sample_green,
  input  logic [ovpc_pkg::SAMPLE_W-1:0]        sample_blue,
  input  logic                                 in_view,
  input  logic [ovpc_pkg::CENTRAL_W-1:0]       central_red,
  input  logic [ovpc_pkg::CENTRAL_W-1:0]       central_green,
  input  logic [ovpc_pkg::CENTRAL_W-1:0]       central_blue,
  input  logic [ovpc_pkg::SAMPLE_W-1:0]        thresh_red,
  input  logic [ovpc_pkg::SAMPLE_W-1:0]        thresh_green,
  input  logic [ovpc_pkg::SAMPLE_W-1:0]        thresh_blue,
  output logic [ovpc_pkg::VOTE_W-1:0]          vote_count,
  output logic [ovpc_pkg::DRAW_W-1:0]          draw_cost,
  output logic [ovpc_pkg::TOTAL_W-1:0]         total_cost,
  output logic                                 few_views
);

  localparam int unsigned CNT_W  = $clog2(VIEWS + 1);
  localparam int unsigned C_W    = ovpc_pkg::CENTRAL_W + FRAC_BITS;
  localparam int unsigned D_W    = (C_W > ovpc_pkg::SAMPLE_W) ? C_W : ovpc_pkg::SAMPLE_W;
  localparam int unsigned E3_W   = D_W + 2;
  localparam int unsigned MULT_W = $clog2(ovpc_pkg::CHAN_SCALE * (VIEWS - 1) + 1);
  localparam int unsigned DEN_W  = MULT_W + FRAC_BITS;
  localparam int unsigned R_W    = (DEN_W > ovpc_pkg::QUO_W) ? DEN_W : ovpc_pkg::QUO_W;
  localparam int unsigned VW     = (CNT_W + 1 > ovpc_pkg::VOTE_W) ? CNT_W + 1
                                                                  : ovpc_pkg::VOTE_W;

  // ---- patch state ----
  logic                        open_r;
  logic [3*ovpc_pkg::CENTRAL_W-1:0] central_r;
  logic [ovpc_pkg::THSUM_W-1:0] thsum_r;
  logic [ovpc_pkg::ESUM_W-1:0] esum_r, esum_nxt;
  logic [CNT_W-1:0]            inview_r, inview_nxt;
  logic [CNT_W-1:0]            outlier_r, outlier_nxt;

  // ---- scoring ----
  logic [3*ovpc_pkg::CENTRAL_W-1:0] central_use;
  logic [ovpc_pkg::THSUM_W-1:0] thsum_in, thsum_use;
  logic [D_W-1:0]              s_r, s_g, s_b, c_r, c_g, c_b, d_r, d_g, d_b;
  logic [E3_W-1:0]             e3;
  logic [ovpc_pkg::ESUM_W:0]   esum_add;

  assign thsum_in = ovpc_pkg::THSUM_W'(thresh_red) + ovpc_pkg::THSUM_W'(thresh_green)
                  + ovpc_pkg::THSUM_W'(thresh_blue);
  // first item of a patch scores against its own central pixel and thresholds
  assign central_use = open_r ? central_r : {central_red, central_green, central_blue};
  assign thsum_use   = open_r ? thsum_r : thsum_in;

  assign s_r = D_W'(sample_red);
  assign s_g = D_W'(sample_green);
  assign s_b = D_W'(sample_blue);
  assign c_r = D_W'(C_W'(central_use[23:16]) << FRAC_BITS);
  assign c_g = D_W'(C_W'(central_use[15:8]) << FRAC_BITS);
  assign c_b = D_W'(C_W'(central_use[7:0]) << FRAC_BITS);
  assign d_r = (s_r > c_r) ? s_r - c_r : c_r - s_r;
  assign d_g = (s_g > c_g) ? s_g - c_g : c_g - s_g;
  assign d_b = (s_b > c_b) ? s_b - c_b : c_b - s_b;
  assign e3  = E3_W'(d_r) + E3_W'(d_g) + E3_W'(d_b);
  assign esum_add = (ovpc_pkg::ESUM_W + 1)'(esum_r) + (ovpc_pkg::ESUM_W + 1)'(e3);

  always_comb begin
    esum_nxt    = esum_r;
    inview_nxt  = inview_r;
    outlier_nxt = outlier_r;
    if (cmd.load) begin
      esum_nxt    = '0;
      inview_nxt  = '0;
      outlier_nxt = '0;
    end else if (cmd.acc && in_view && (inview_r < CNT_W'(VIEWS))) begin
      inview_nxt = inview_r + 1'b1;
      if (E3_W'(thsum_use) < e3) begin
        outlier_nxt = outlier_r + 1'b1;
      end else begin
        esum_nxt = esum_add[ovpc_pkg::ESUM_W] ? ovpc_pkg::ESUM_MAX
                                              : esum_add[ovpc_pkg::ESUM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r    <= 1'b0;
      esum_r    <= '0;
      inview_r  <= '0;
      outlier_r <= '0;
    end else begin
      esum_r    <= esum_nxt;
      inview_r  <= inview_nxt;
      outlier_r <= outlier_nxt;
      if (cmd.load)                 open_r <= 1'b0;
      else if (cmd.acc)             open_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc && !open_r) begin
      central_r <= {central_red, central_green, central_blue};
      thsum_r   <= thsum_in;
    end
  end

  // ---- divider: esum * 2^16 / (765 * 2^FRAC_BITS * (n - 1)) ----
  logic [MULT_W-1:0]           prod;
  logic [DEN_W-1:0]            den_r;
  logic [R_W-1:0]              rem_r, num_hi, den_ext;
  logic [R_W:0]                trial;
  logic [ovpc_pkg::QUO_W-1:0]  lo_r, quo_r;
  logic                        few_r, sat_r, fits;

  assign prod    = MULT_W'(inview_r - 1'b1) * MULT_W'(ovpc_pkg::CHAN_SCALE);
  assign num_hi  = R_W'(esum_r[ovpc_pkg::ESUM_W-1:2]);
  assign den_ext = R_W'(den_r);
  assign trial   = {rem_r, lo_r[ovpc_pkg::QUO_W-1]};
  assign fits    = trial >= (R_W + 1)'(den_ext);

  assign stat.few = (inview_r <= CNT_W'(1));
  assign stat.sat = (num_hi >= den_ext);

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      den_r <= DEN_W'(prod) << FRAC_BITS;
      few_r <= stat.few;
      sat_r <= 1'b0;
    end
    if (cmd.check) begin
      sat_r <= stat.sat;
      rem_r <= num_hi;
      lo_r  <= {esum_r[1:0], 16'h0000};
      quo_r <= '0;
    end
    if (cmd.step) begin
      rem_r <= fits ? R_W'(trial - (R_W + 1)'(den_ext)) : trial[R_W-1:0];
      lo_r  <= lo_r << 1;
      quo_r <= {quo_r[ovpc_pkg::QUO_W-2:0], fits};
    end
  end

  // ---- result ----
  logic [VW-1:0]                votes;
  logic [ovpc_pkg::DRAW_W-1:0]  draw;
  logic [ovpc_pkg::VOTE_W-1:0]  vote_r;
  logic [ovpc_pkg::DRAW_W-1:0]  draw_r;
  logic [ovpc_pkg::TOTAL_W-1:0] total_r;
  logic                         few_views_r;

  assign votes = VW'(VIEWS) - VW'(inview_r) + VW'(outlier_r);

  always_comb begin
    priority if (few_r)                     draw = '0;
    else if (sat_r)                         draw = ovpc_pkg::DRAW_MAX;
    else if (quo_r > ovpc_pkg::DRAW_MAX)    draw = ovpc_pkg::DRAW_MAX;
    else                                    draw = quo_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      vote_r      <= votes[ovpc_pkg::VOTE_W-1:0];
      draw_r      <= draw;
      total_r     <= ovpc_pkg::TOTAL_W'({votes[ovpc_pkg::VOTE_W-1:0], 16'h0000})
                   + ovpc_pkg::TOTAL_W'(draw);
      few_views_r <= few_r;
    end
  end

  assign vote_count = vote_r;
  assign draw_cost  = draw_r;
  assign total_cost = total_r;
  assign few_views  = few_views_r;

endmodule

// ===== design/occlusion_vote_patch_cost.sv =====
// ============================================================================
// occlusion_vote_patch_cost
// Occlusion-aware vote cost of one light-field angular patch.
// ============================================================================
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+----------------------------------
//  in_     | in        | in_valid/in_stall  | view sample, flags, central, thresh
//  out_    | out       | out_valid/out_stall| votes, draw cost, total, few flag
//
//  Samples of a patch are taken one per cycle. After the request that carries
//  last_view the input stalls while the serial divider runs: divisor multiply,
//  overflow test, 18 restoring steps and result load; with at most one in-view
//  sample only divisor setup and result load; on quotient overflow setup,
//  overflow test and result load. The result load waits only while out_ is
//  stalled; the next patch is not taken until then. The result sits in an
//  output register, held steady while out_stall is high. Reset (rst_n low,
//  synchronous) clears the sequencer, the patch accumulators and out_valid.
//
// Scoring: E3 = sum of |sample - central << FRAC_BITS| over three channels;
// an in-view sample with E3 above the latched threshold sum is an outlier
// vote, otherwise E3 is added to a saturating 20-bit error sum. Out-of-view
// samples are counted as occluded at the end (VIEWS - in-view count).
// draw cost = error_sum * 2^16 / (765 * 2^FRAC_BITS * (in-view - 1)), Q2.16.
// ============================================================================
module occlusion_vote_patch_cost #(
  parameter int unsigned VIEWS     = 81,
  parameter int unsigned FRAC_BITS = 4
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [ovpc_pkg::SAMPLE_W-1:0]   in_sample_red,
  input  logic [ovpc_pkg::SAMPLE_W-1:0]   in_sample_green,
  input  logic [ovpc_pkg::SAMPLE_W-1:0]   in_sample_blue,
  input  logic                            in_in_view,
  input  logic [ovpc_pkg::CENTRAL_W-1:0]  in_central_red,
  input  logic [ovpc_pkg::CENTRAL_W-1:0]  in_central_green,
  input  logic [ovpc_pkg::CENTRAL_W-1:0]  in_central_blue,
  input  logic [ovpc_pkg::SAMPLE_W-1:0]   in_thresh_red,
  input  logic [ovpc_pkg::SAMPLE_W-1:0]   in_thresh_green,
  input  logic [ovpc_pkg::SAMPLE_W-1:0]   in_thresh_blue,
  input  logic                            in_last_view,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [ovpc_pkg::VOTE_W-1:0]     out_vote_count,
  output logic [ovpc_pkg::DRAW_W-1:0]     out_draw_cost,
  output logic [ovpc_pkg::TOTAL_W-1:0]    out_total_cost,
  output logic                            out_few_views
);

  ovpc_pkg::ctrl_cmd_t cmd;
  ovpc_pkg::dp_stat_t  stat;

  // sequencer: accept window, divide steps, output slot
  ovpc_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_last_view (in_last_view),
    .out_stall    (out_stall),
    .stat         (stat),
    .cmd          (cmd),
    .in_stall     (in_stall),
    .out_valid    (out_valid)
  );

  // scoring, accumulators, divider and result registers
  ovpc_dpath #(
    .VIEWS     (VIEWS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .sample_red    (in_sample_red),
    .sample_green  (in_sample_green),
    .sample_blue   (in_sample_blue),
    .in_view       (in_in_view),
    .central_red   (in_central_red),
    .central_green (in_central_green),
    .central_blue  (in_central_blue),
    .thresh_red    (in_thresh_red),
    .thresh_green  (in_thresh_green),
    .thresh_blue   (in_thresh_blue),
    .vote_count    (out_vote_count),
    .draw_cost     (out_draw_cost),
    .total_cost    (out_total_cost),
    .few_views     (out_few_views)
  );

endmodule

// ===== design/ovpc_chk.sv =====
// ============================================================================
// ovpc_chk
// Port-level checks of the occlusion vote patch cost block.
// ============================================================================
module ovpc_chk (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic                            in_last_view,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [ovpc_pkg::VOTE_W-1:0]     out_vote_count,
  input  logic [ovpc_pkg::DRAW_W-1:0]     out_draw_cost,
  input  logic [ovpc_pkg::TOTAL_W-1:0]    out_total_cost,
  input  logic                            out_few_views
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_total_cost)
                               && $stable(out_draw_cost) && $stable(out_few_views))
    else $error("result changed while stalled");

  // end of patch closes the input while the divide runs
  a_close: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_last_view |=> in_stall)
    else $error("input open right after last view");

  a_few: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_few_views |-> out_draw_cost == '0)
    else $error("few views with nonzero draw cost");

  a_draw_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_draw_cost <= ovpc_pkg::DRAW_MAX)
    else $error("draw cost above saturation");

  a_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_total_cost == ovpc_pkg::TOTAL_W'({out_vote_count, 16'h0000})
                                  + ovpc_pkg::TOTAL_W'(out_draw_cost))
    else $error("total cost mismatch");

endmodule

bind occlusion_vote_patch_cost ovpc_chk u_ovpc_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .in_last_view   (in_last_view),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_vote_count (out_vote_count),
  .out_draw_cost  (out_draw_cost),
  .out_total_cost (out_total_cost),
  .out_few_views  (out_few_views)
);

// ===== sim/tb_occlusion_vote_patch_cost.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_occlusion_vote_patch_cost
// Self-checking bench for the occlusion vote patch cost block.
// Patches of view samples are queued and sent over the in_ channel. A
// behavioral scorer predicts votes, draw cost, total cost and the few-views
// flag for each patch. Every result from out_ is checked field by field
// against the oldest prediction. The run has three traffic phases: sender
// idles 35% and receiver 56%, then the reverse, then no idling with one long
// receiver hold-off.
// ============================================================================
module tb_occlusion_vote_patch_cost;

  localparam int unsigned VIEWS     = 81;
  localparam int unsigned FRAC      = 4;
  localparam int unsigned HOLD_LEN  = 400;   // long receiver hold-off, cycles
  localparam int unsigned IDLE_MAX  = 5000;  // watchdog: cycles with no traffic
  localparam int unsigned TAIL_WAIT = 40;    // settle time after last result

  // one view sample request as it goes over in_
  typedef struct {
    logic [ovpc_pkg::SAMPLE_W-1:0]  s_red, s_green, s_blue;
    logic                           in_view;
    logic [ovpc_pkg::CENTRAL_W-1:0] c_red, c_green, c_blue;
    logic [ovpc_pkg::SAMPLE_W-1:0]  t_red, t_green, t_blue;
    logic                           last_view;
  } view_req_t;

  // one patch score as it comes back over out_
  typedef struct {
    logic [ovpc_pkg::VOTE_W-1:0]  votes;
    logic [ovpc_pkg::DRAW_W-1:0]  draw;
    logic [ovpc_pkg::TOTAL_W-1:0] total;
    logic                         few;
  } patch_score_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                           in_valid         = 1'b0;
  logic                           in_stall;
  logic [ovpc_pkg::SAMPLE_W-1:0]  in_sample_red    = '0;
  logic [ovpc_pkg::SAMPLE_W-1:0]  in_sample_green  = '0;
  logic [ovpc_pkg::SAMPLE_W-1:0]  in_sample_blue   = '0;
  logic                           in_in_view       = 1'b0;
  logic [ovpc_pkg::CENTRAL_W-1:0] in_central_red   = '0;
  logic [ovpc_pkg::CENTRAL_W-1:0] in_central_green = '0;
  logic [ovpc_pkg::CENTRAL_W-1:0] in_central_blue  = '0;
  logic [ovpc_pkg::SAMPLE_W-1:0]  in_thresh_red    = '0;
  logic [ovpc_pkg::SAMPLE_W-1:0]  in_thresh_green  = '0;
  logic [ovpc_pkg::SAMPLE_W-1:0]  in_thresh_blue   = '0;
  logic                           in_last_view     = 1'b0;

  logic                           out_valid;
  logic                           out_stall        = 1'b0;
  logic [ovpc_pkg::VOTE_W-1:0]    out_vote_count;
  logic [ovpc_pkg::DRAW_W-1:0]    out_draw_cost;
  logic [ovpc_pkg::TOTAL_W-1:0]   out_total_cost;
  logic                           out_few_views;

  occlusion_vote_patch_cost #(
    .VIEWS     (VIEWS),
    .FRAC_BITS (FRAC)
  ) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_sample_red    (in_sample_red),
    .in_sample_green  (in_sample_green),
    .in_sample_blue   (in_sample_blue),
    .in_in_view       (in_in_view),
    .in_central_red   (in_central_red),
    .in_central_green (in_central_green),
    .in_central_blue  (in_central_blue),
    .in_thresh_red    (in_thresh_red),
    .in_thresh_green  (in_thresh_green),
    .in_thresh_blue   (in_thresh_blue),
    .in_last_view     (in_last_view),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_vote_count   (out_vote_count),
    .out_draw_cost    (out_draw_cost),
    .out_total_cost   (out_total_cost),
    .out_few_views    (out_few_views)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Shared bench state
  // --------------------------------------------------------------------------
  view_req_t    view_q[$];          // requests waiting to be driven
  patch_score_t pending_scores[$];  // predicted scores not yet returned
  view_req_t    cur_req;            // request currently on in_
  int unsigned  tx_idle_pct = 35;
  int unsigned  rx_idle_pct = 56;
  bit           hold_req    = 1'b0; // asks the monitor for a long hold-off
  int unsigned  hold_left   = 0;
  int unsigned  err_count   = 0;
  int unsigned  quiet_cycles = 0;
  int unsigned  items_queued = 0;

  // Scorer state: mirrors the patch accumulators and latched patch header
  logic [ovpc_pkg::ESUM_W-1:0]    err_sum       = '0;
  logic [ovpc_pkg::VOTE_W-1:0]    seen_inview   = '0;
  logic [ovpc_pkg::VOTE_W-1:0]    seen_outliers = '0;
  logic [ovpc_pkg::CENTRAL_W-1:0] lat_red       = '0;
  logic [ovpc_pkg::CENTRAL_W-1:0] lat_green     = '0;
  logic [ovpc_pkg::CENTRAL_W-1:0] lat_blue      = '0;
  logic [ovpc_pkg::THSUM_W-1:0]   lat_thsum     = '0;
  bit                             mid_patch     = 1'b0;

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    err_count++;
  endtask

  // |sample - central scaled to 8.FRAC|, one channel
  function automatic logic [ovpc_pkg::SAMPLE_W-1:0] chan_err(
      input logic [ovpc_pkg::SAMPLE_W-1:0] s,
      input logic [ovpc_pkg::CENTRAL_W-1:0] c);
    logic [ovpc_pkg::SAMPLE_W-1:0] ctr;
    ctr = ovpc_pkg::SAMPLE_W'(c) << FRAC;
    return (s > ctr) ? s - ctr : ctr - s;
  endfunction

  // Advance the scorer by one accepted request; queue a score on last_view.
  task automatic score_view(input view_req_t v);
    logic [ovpc_pkg::THSUM_W-1:0] e3;
    logic [ovpc_pkg::ESUM_W:0]    wide_sum;
    longint unsigned              den, quo, tot;
    int unsigned                  votes;
    patch_score_t                 s;
    // first request of a patch latches the header
    if (!mid_patch) begin
      lat_red   = v.c_red;
      lat_green = v.c_green;
      lat_blue  = v.c_blue;
      lat_thsum = ovpc_pkg::THSUM_W'(v.t_red) + ovpc_pkg::THSUM_W'(v.t_green)
                + ovpc_pkg::THSUM_W'(v.t_blue);
      mid_patch = 1'b1;
    end
    if (v.in_view) begin
      e3 = ovpc_pkg::THSUM_W'(chan_err(v.s_red, lat_red))
         + ovpc_pkg::THSUM_W'(chan_err(v.s_green, lat_green))
         + ovpc_pkg::THSUM_W'(chan_err(v.s_blue, lat_blue));
      // counters saturate at VIEWS: extra views are simply dropped
      if (seen_inview < VIEWS) begin
        seen_inview++;
        if (e3 > lat_thsum) begin
          seen_outliers++;
        end else begin
          wide_sum = (ovpc_pkg::ESUM_W+1)'(err_sum) + (ovpc_pkg::ESUM_W+1)'(e3);
          err_sum  = (wide_sum > ovpc_pkg::ESUM_MAX) ? ovpc_pkg::ESUM_MAX
                                                     : wide_sum[ovpc_pkg::ESUM_W-1:0];
        end
      end
    end
    if (v.last_view) begin
      votes = VIEWS - seen_inview + seen_outliers;
      s.few = (seen_inview <= 1);
      quo   = 0;
      if (!s.few) begin
        den = longint'(ovpc_pkg::CHAN_SCALE) * (64'd1 << FRAC)
            * longint'(seen_inview - 1);
        quo = (longint'(err_sum) << 16) / den;
        if (quo > ovpc_pkg::DRAW_MAX) quo = ovpc_pkg::DRAW_MAX;
      end
      tot     = (longint'(votes) << 16) + quo;
      s.votes = votes[ovpc_pkg::VOTE_W-1:0];
      s.draw  = quo[ovpc_pkg::DRAW_W-1:0];
      s.total = tot[ovpc_pkg::TOTAL_W-1:0];
      pending_scores = {pending_scores, s};
      err_sum       = '0;
      seen_inview   = '0;
      seen_outliers = '0;
      mid_patch     = 1'b0;
    end
  endtask

  task automatic check_score();
    patch_score_t want;
    if (pending_scores.size() == 0) begin
      report_mismatch($sformatf("result with none pending: votes=%0d draw=%0d",
                                out_vote_count, out_draw_cost));
      return;
    end
    want = pending_scores.pop_front();
    if (out_vote_count !== want.votes)
      report_mismatch($sformatf("vote_count got %0d want %0d", out_vote_count, want.votes));
    if (out_draw_cost !== want.draw)
      report_mismatch($sformatf("draw_cost got %0d want %0d", out_draw_cost, want.draw));
    if (out_total_cost !== want.total)
      report_mismatch($sformatf("total_cost got %0d want %0d", out_total_cost, want.total));
    if (out_few_views !== want.few)
      report_mismatch($sformatf("few_views got %0b want %0b", out_few_views, want.few));
  endtask

  // --------------------------------------------------------------------------
  // Driver: presents the next queued request whenever in_ is free. The
  // payload only moves after an accept or while in_valid is low.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) score_view(cur_req);
      if (!in_valid || !in_stall) begin
        if (view_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          cur_req = view_q.pop_front();
          in_valid         <= 1'b1;
          in_sample_red    <= cur_req.s_red;
          in_sample_green  <= cur_req.s_green;
          in_sample_blue   <= cur_req.s_blue;
          in_in_view       <= cur_req.in_view;
          in_central_red   <= cur_req.c_red;
          in_central_green <= cur_req.c_green;
          in_central_blue  <= cur_req.c_blue;
          in_thresh_red    <= cur_req.t_red;
          in_thresh_green  <= cur_req.t_green;
          in_thresh_blue   <= cur_req.t_blue;
          in_last_view     <= cur_req.last_view;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks accepted results, drives out_stall. A hold-off request
  // keeps out_stall high while the HOLD_LEN countdown runs, so the block backs
  // up and has to stall its input while the driver keeps offering.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_score();
      if (hold_req) begin
        hold_left = HOLD_LEN;
        hold_req  = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  // Watchdog: too long with nothing moving on either channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= IDLE_MAX) begin
        $display("watchdog: no traffic for %0d cycles", IDLE_MAX);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  task automatic add_view(input int sr, input int sg, input int sb, input bit vis,
                          input int cr, input int cg, input int cb,
                          input int tr, input int tg, input int tb, input bit last);
    view_req_t v;
    v.s_red     = ovpc_pkg::SAMPLE_W'(sr);
    v.s_green   = ovpc_pkg::SAMPLE_W'(sg);
    v.s_blue    = ovpc_pkg::SAMPLE_W'(sb);
    v.in_view   = vis;
    v.c_red     = ovpc_pkg::CENTRAL_W'(cr);
    v.c_green   = ovpc_pkg::CENTRAL_W'(cg);
    v.c_blue    = ovpc_pkg::CENTRAL_W'(cb);
    v.t_red     = ovpc_pkg::SAMPLE_W'(tr);
    v.t_green   = ovpc_pkg::SAMPLE_W'(tg);
    v.t_blue    = ovpc_pkg::SAMPLE_W'(tb);
    v.last_view = last;
    view_q = {view_q, v};
    items_queued++;
  endtask

  // sample close to the scaled central value, clamped to the field
  function automatic int near_ctr(input int c, input int spread);
    int val;
    val = (c << FRAC) + int'($urandom_range(2 * spread)) - spread;
    if (val < 0) val = 0;
    if (val > 4095) val = 4095;
    return val;
  endfunction

  // One well-formed patch with random content. Header fields on later
  // requests are random too; the block must ignore them.
  task automatic push_patch(input int len, input int vis_pct);
    int cr, cg, cb, tr, tg, tb, spread;
    bit wild_th;
    cr = $urandom_range(255);
    cg = $urandom_range(255);
    cb = $urandom_range(255);
    wild_th = ($urandom_range(99) < 15);
    tr = wild_th ? $urandom_range(4095) : $urandom_range(600);
    tg = wild_th ? $urandom_range(4095) : $urandom_range(600);
    tb = wild_th ? $urandom_range(4095) : $urandom_range(600);
    spread = ($urandom_range(1) != 0) ? 400 : 60;
    for (int i = 0; i < len; i++) begin
      if (i == 0) begin
        add_view(near_ctr(cr, spread), near_ctr(cg, spread), near_ctr(cb, spread),
                 $urandom_range(99) < vis_pct, cr, cg, cb, tr, tg, tb, len == 1);
      end else if ($urandom_range(99) < 20) begin
        // far-off sample anywhere in the field
        add_view($urandom_range(4095), $urandom_range(4095), $urandom_range(4095),
                 $urandom_range(99) < vis_pct, $urandom_range(255), $urandom_range(255),
                 $urandom_range(255), $urandom_range(4095), $urandom_range(4095),
                 $urandom_range(4095), i == len - 1);
      end else begin
        add_view(near_ctr(cr, spread), near_ctr(cg, spread), near_ctr(cb, spread),
                 $urandom_range(99) < vis_pct, $urandom_range(255), $urandom_range(255),
                 $urandom_range(255), $urandom_range(4095), $urandom_range(4095),
                 $urandom_range(4095), i == len - 1);
      end
    end
  endtask

  // Mostly short patches so results come often; a few full or overfull ones.
  task automatic push_random(input int n_items);
    int stop, pick, len;
    stop = items_queued + n_items;
    while (items_queued < stop) begin
      pick = $urandom_range(99);
      if (pick < 4)       len = $urandom_range(90, 81);
      else if (pick < 20) len = $urandom_range(3, 1);
      else                len = $urandom_range(24, 4);
      push_patch(len, ($urandom_range(99) < 6) ? 10 : 88);
    end
  endtask

  // Sender pause: nothing more is queued until every score is back.
  task automatic wait_drained();
    while (view_q.size() != 0 || in_valid || pending_scores.size() != 0)
      @(negedge clk);
  endtask

  initial begin
    // Directed patches
    // single request, in view, sample equals central: few views, no draw
    add_view(0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 1);
    // single request, out of view: all views count as votes
    add_view(4095, 4095, 4095, 0, 255, 255, 255, 4095, 4095, 4095, 1);
    // two maximal-error inliers: draw cost saturates at 2.0
    add_view(4095, 4095, 4095, 1, 0, 0, 0, 4095, 4095, 4095, 0);
    add_view(4095, 4095, 4095, 1, 255, 255, 255, 0, 0, 0, 1);
    // zero thresholds, far samples: both in-view samples are outliers
    add_view(0, 0, 0, 1, 255, 255, 255, 0, 0, 0, 0);
    add_view(0, 0, 0, 1, 0, 0, 0, 4095, 4095, 4095, 1);
    // error exactly at threshold sum is an inlier, one above is an outlier
    add_view(1610, 780, 3230, 1, 100, 50, 200, 10, 20, 30, 0);
    add_view(1610, 780, 3231, 1, 0, 0, 0, 0, 0, 0, 0);
    add_view(4095, 0, 4095, 0, 255, 0, 255, 4095, 0, 4095, 0);
    add_view(1600, 800, 3200, 1, 7, 7, 7, 7, 7, 7, 1);
    // patch with every view out of image
    add_view(123, 456, 789, 0, 12, 34, 56, 78, 90, 12, 0);
    add_view(4095, 4095, 4095, 0, 255, 255, 255, 4095, 4095, 4095, 0);
    add_view(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1);
    push_patch(4, 100);

    // Phase 1: sender idles 35%, receiver 56%
    push_random(400);
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    wait_drained();

    // Phase 2: roles swapped
    tx_idle_pct = 56;
    rx_idle_pct = 35;
    push_random(400);
    wait_drained();

    // Phase 3: no idling; a long receiver hold-off backs the block up,
    // starting with an overfull patch to hit counter saturation
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_req    = 1'b1;
    push_patch(88, 100);
    push_random(350);
    wait_drained();

    repeat (TAIL_WAIT) @(negedge clk);
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
